// ===== hw/rtl/lc3_instruction_executor_defines.svh =====
// ----------------------------------------------------------------------------
// lc3_instruction_executor_defines
// Assertion macros used by the processor core controller.
// ----------------------------------------------------------------------------
`ifndef LC3_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define LC3_INSTRUCTION_EXECUTOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define LC3_ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Implication whose consequent is checked at the next clock edge.
`define LC3_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== hw/rtl/lc3_pkg.sv =====
// ----------------------------------------------------------------------------
// lc3_pkg
// Types, constants and decode helpers shared by the processor core.
// ----------------------------------------------------------------------------
package lc3_pkg;

    localparam int ADDRESS_BITS_DEFAULT = 16;

    localparam logic [15:0] SSP_RESET   = 16'h1000;
    localparam logic [15:0] VTB_RESET   = 16'h0100;
    localparam logic [15:0] PC_RESET    = 16'h3000;
    localparam logic [15:0] MCR_ADDRESS = 16'hFFFE;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_SETPC = 2'd1;
    localparam logic [1:0] MODE_EXEC  = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    localparam logic [1:0] EXC_NONE     = 2'd0;
    localparam logic [1:0] EXC_PRIV     = 2'd1;
    localparam logic [1:0] EXC_RESERVED = 2'd2;

    localparam logic [0:0] CFG_SSP = 1'b0;
    localparam logic [0:0] CFG_VTB = 1'b1;

    localparam logic [3:0] OP_BR   = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_LD   = 4'd2;
    localparam logic [3:0] OP_ST   = 4'd3;
    localparam logic [3:0] OP_JSR  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_LDR  = 4'd6;
    localparam logic [3:0] OP_STR  = 4'd7;
    localparam logic [3:0] OP_RTI  = 4'd8;
    localparam logic [3:0] OP_NOT  = 4'd9;
    localparam logic [3:0] OP_LDI  = 4'd10;
    localparam logic [3:0] OP_STI  = 4'd11;
    localparam logic [3:0] OP_JMP  = 4'd12;
    localparam logic [3:0] OP_RES  = 4'd13;
    localparam logic [3:0] OP_LEA  = 4'd14;
    localparam logic [3:0] OP_TRAP = 4'd15;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] address;
        logic [15:0] write_data;
    } in_word_t;

    typedef struct packed {
        logic [15:0] pc_after;
        logic [15:0] instruction_word;
        logic [15:0] status_word;
        logic [15:0] read_data;
        logic        register_written;
        logic [2:0]  register_index;
        logic [15:0] register_value;
        logic [1:0]  exception_taken;
        logic        machine_running;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DECODE,
        ST_MEM1,
        ST_MEM2,
        ST_EXC1,
        ST_EXC2,
        ST_EXC3,
        ST_MCR,
        ST_DONE
    } state_t;

    // Address source selected by the controller for the memory port.
    typedef enum logic [2:0] {
        AS_INPUT,
        AS_PC,
        AS_EA,
        AS_MDR,
        AS_MCR
    } addr_sel_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic      load_item;
        logic      mem_we;
        logic      mem_rd;
        addr_sel_t addr_sel;
        logic      fetch;
        logic      decode;
        logic      mem1;
        logic      mem2;
        logic      exc1;
        logic      exc2;
        logic      exc3;
        logic      mcr;
    } ctrl_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] op;
        logic       user_mode;
    } stat_t;

    function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
        logic [15:0] r;
        r = v;
        for (int i = 0; i < 16; i++)
        begin
            if (i >= bits)
            begin
                r[i] = v[bits - 1];
            end
        end
        return r;
    endfunction

    function automatic logic [15:0] codes(input logic [15:0] psr, input logic [15:0] v);
        logic [15:0] s;
        s = {psr[15:8], 8'h00};
        if (v == 16'h0000)
        begin
            s[1] = 1'b1;
        end
        else if (v[15])
        begin
            s[2] = 1'b1;
        end
        else
        begin
            s[0] = 1'b1;
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/lc3_ctrl.sv =====
// ----------------------------------------------------------------------------
// lc3_ctrl
// Sequencer that steps the datapath through fetch, memory and exception work.
// ----------------------------------------------------------------------------
`include "lc3_instruction_executor_defines.svh"
module lc3_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  lc3_pkg::stat_t stat,
    output lc3_pkg::ctrl_t ctrl
);

    lc3_pkg::state_t state_reg;
    lc3_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lc3_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lc3_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lc3_pkg::ST_FETCH;
                end
            end
            lc3_pkg::ST_FETCH:
            begin
                if (stat.mode == lc3_pkg::MODE_EXEC)
                begin
                    state_next = lc3_pkg::ST_DECODE;
                end
                else
                begin
                    state_next = lc3_pkg::ST_MCR;
                end
            end
            lc3_pkg::ST_DECODE:
            begin
                case (stat.op)
                    lc3_pkg::OP_LD, lc3_pkg::OP_LDI, lc3_pkg::OP_ST, lc3_pkg::OP_STI,
                    lc3_pkg::OP_LDR, lc3_pkg::OP_STR, lc3_pkg::OP_TRAP:
                        state_next = lc3_pkg::ST_MEM1;
                    lc3_pkg::OP_RTI:
                        state_next = stat.user_mode ? lc3_pkg::ST_EXC1 : lc3_pkg::ST_MEM1;
                    lc3_pkg::OP_RES:
                        state_next = lc3_pkg::ST_EXC1;
                    default:
                        state_next = lc3_pkg::ST_MCR;
                endcase
            end
            lc3_pkg::ST_MEM1:
            begin
                if (stat.op == lc3_pkg::OP_LDI || stat.op == lc3_pkg::OP_STI
                    || stat.op == lc3_pkg::OP_RTI)
                begin
                    state_next = lc3_pkg::ST_MEM2;
                end
                else
                begin
                    state_next = lc3_pkg::ST_MCR;
                end
            end
            lc3_pkg::ST_MEM2: state_next = lc3_pkg::ST_MCR;
            lc3_pkg::ST_EXC1: state_next = lc3_pkg::ST_EXC2;
            lc3_pkg::ST_EXC2: state_next = lc3_pkg::ST_EXC3;
            lc3_pkg::ST_EXC3: state_next = lc3_pkg::ST_MCR;
            lc3_pkg::ST_MCR:  state_next = lc3_pkg::ST_DONE;
            lc3_pkg::ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = lc3_pkg::ST_IDLE;
                end
            end
            default: state_next = lc3_pkg::ST_IDLE;
        endcase
    end

    // Outputs. Decode addresses memory with the effective address formed from
    // the instruction word or a stack pointer; the read data register is
    // consumed in the following state.
    always_comb
    begin
        ctrl = '0;
        ctrl.addr_sel = lc3_pkg::AS_PC;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            lc3_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                ctrl.load_item = in_valid;
            end
            lc3_pkg::ST_FETCH:
            begin
                ctrl.fetch = 1'b1;
                ctrl.addr_sel = lc3_pkg::AS_INPUT;
                // Write, read and fetch all use the port here.
                ctrl.mem_we = (stat.mode == lc3_pkg::MODE_WRITE);
                ctrl.mem_rd = (stat.mode != lc3_pkg::MODE_WRITE);
            end
            lc3_pkg::ST_DECODE:
            begin
                ctrl.decode = 1'b1;
                ctrl.addr_sel = lc3_pkg::AS_EA;
                ctrl.mem_rd = (stat.op != lc3_pkg::OP_ST) && (stat.op != lc3_pkg::OP_STR);
                ctrl.mem_we = (stat.op == lc3_pkg::OP_ST) || (stat.op == lc3_pkg::OP_STR);
            end
            lc3_pkg::ST_MEM1:
            begin
                ctrl.mem1 = 1'b1;
                // RTI reads the second stack word; the indirect ops follow the pointer.
                ctrl.addr_sel = (stat.op == lc3_pkg::OP_RTI) ? lc3_pkg::AS_EA
                                                             : lc3_pkg::AS_MDR;
                ctrl.mem_rd = (stat.op == lc3_pkg::OP_LDI) || (stat.op == lc3_pkg::OP_RTI);
                ctrl.mem_we = (stat.op == lc3_pkg::OP_STI);
            end
            lc3_pkg::ST_MEM2: ctrl.mem2 = 1'b1;
            lc3_pkg::ST_EXC1:
            begin
                ctrl.exc1 = 1'b1;
                ctrl.addr_sel = lc3_pkg::AS_EA;
                ctrl.mem_we = 1'b1;
            end
            lc3_pkg::ST_EXC2:
            begin
                ctrl.exc2 = 1'b1;
                ctrl.addr_sel = lc3_pkg::AS_EA;
                ctrl.mem_we = 1'b1;
            end
            lc3_pkg::ST_EXC3:
            begin
                ctrl.exc3 = 1'b1;
                ctrl.addr_sel = lc3_pkg::AS_EA;
                ctrl.mem_rd = 1'b1;
            end
            lc3_pkg::ST_MCR:
            begin
                ctrl.mcr = 1'b1;
                ctrl.addr_sel = lc3_pkg::AS_MCR;
                ctrl.mem_rd = 1'b1;
            end
            lc3_pkg::ST_DONE: out_valid = 1'b1;
            default: ctrl = '0;
        endcase
    end

    `LC3_ASSERT_IMPLY(a_ready_idle, clk, rst_n, in_ready, !out_valid)
    `LC3_ASSERT_IMPLY(a_port_excl, clk, rst_n, ctrl.mem_we, !ctrl.mem_rd)
    `LC3_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule

// ===== hw/rtl/lc3_datapath.sv =====
// ----------------------------------------------------------------------------
// lc3_datapath
// Register file, PC, PSR, word memory and result register of the core.
// ----------------------------------------------------------------------------
module lc3_datapath
#(
    parameter int ADDRESS_BITS = lc3_pkg::ADDRESS_BITS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  lc3_pkg::in_word_t in_word,
    input  lc3_pkg::ctrl_t    ctrl,
    output lc3_pkg::stat_t    stat,
    output lc3_pkg::out_word_t out_word
);

    logic [15:0] mem [2**ADDRESS_BITS];
    logic [15:0] mdr_reg;

    logic [15:0] ssp_reg;
    logic [15:0] vtb_reg;
    logic [15:0] gpr_reg [8];
    logic [15:0] pc_reg;
    logic [15:0] psr_reg;
    lc3_pkg::in_word_t item_reg;
    logic [15:0] ir_reg;
    logic [15:0] ea_reg;
    logic [15:0] st_data_reg;
    logic [15:0] old_psr_reg;
    logic        wr_reg;
    logic [2:0]  widx_reg;
    logic [15:0] wval_reg;
    logic [1:0]  exc_reg;
    logic [15:0] rdata_reg;

    logic [15:0] mem_addr;
    logic [15:0] mem_wdata;
    logic [3:0]  op;
    logic [2:0]  dr;
    logic [2:0]  sr1;
    logic [15:0] pc_inc;
    logic [15:0] pc9_f;
    logic [15:0] operand_b;
    logic [15:0] alu_v;
    logic [15:0] ea_d;

    assign op  = mdr_reg[15:12];
    assign dr  = mdr_reg[11:9];
    assign sr1 = mdr_reg[8:6];
    assign pc_inc = pc_reg + 16'd1;
    assign pc9_f  = pc_inc + lc3_pkg::sext(mdr_reg, 9);
    assign operand_b = mdr_reg[5] ? lc3_pkg::sext(mdr_reg, 5) : gpr_reg[mdr_reg[2:0]];

    // Effective address formed in decode from the instruction or stack pointer.
    always_comb
    begin
        case (op)
            lc3_pkg::OP_LDR, lc3_pkg::OP_STR:
                ea_d = gpr_reg[sr1] + lc3_pkg::sext(mdr_reg, 6);
            lc3_pkg::OP_TRAP: ea_d = {8'h00, mdr_reg[7:0]};
            lc3_pkg::OP_RTI:  ea_d = psr_reg[15] ? ssp_reg - 16'd1 : gpr_reg[6];
            lc3_pkg::OP_RES:  ea_d = ssp_reg - 16'd1;
            default:          ea_d = pc9_f;
        endcase
    end

    // Address and data routed to the memory port. RTI reads its stack with
    // ea then ea+1 on the effective address path.
    always_comb
    begin
        case (ctrl.addr_sel)
            lc3_pkg::AS_INPUT: mem_addr = (item_reg.mode == lc3_pkg::MODE_EXEC)
                                          ? pc_reg : item_reg.address;
            lc3_pkg::AS_EA:
            begin
                if (ctrl.decode)
                begin
                    mem_addr = ea_d;
                end
                else if (ctrl.mem1)
                begin
                    mem_addr = ea_reg + 16'd1;
                end
                else
                begin
                    mem_addr = ea_reg;
                end
            end
            lc3_pkg::AS_MDR:   mem_addr = mdr_reg;
            lc3_pkg::AS_MCR:   mem_addr = lc3_pkg::MCR_ADDRESS;
            default:           mem_addr = pc_reg;
        endcase
        mem_wdata = item_reg.write_data;
        if (ctrl.decode)
        begin
            mem_wdata = gpr_reg[dr];
        end
        else if (ctrl.mem1)
        begin
            mem_wdata = st_data_reg;
        end
        else if (ctrl.exc1)
        begin
            mem_wdata = old_psr_reg;
        end
        else if (ctrl.exc2)
        begin
            mem_wdata = pc_reg;
        end
    end

    // Single-port word memory with registered read.
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_we)
        begin
            mem[mem_addr[ADDRESS_BITS-1:0]] <= mem_wdata;
        end
        if (ctrl.mem_rd)
        begin
            mdr_reg <= mem[mem_addr[ADDRESS_BITS-1:0]];
        end
    end

    // Combinational ALU result for ADD, AND, NOT and LEA.
    always_comb
    begin
        case (op)
            lc3_pkg::OP_ADD: alu_v = gpr_reg[sr1] + operand_b;
            lc3_pkg::OP_AND: alu_v = gpr_reg[sr1] & operand_b;
            lc3_pkg::OP_NOT: alu_v = ~gpr_reg[sr1];
            default:         alu_v = pc9_f;
        endcase
    end

    // Architectural state and sequencing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ssp_reg <= lc3_pkg::SSP_RESET;
            vtb_reg <= lc3_pkg::VTB_RESET;
            for (int i = 0; i < 8; i++)
            begin
                gpr_reg[i] <= 16'h0000;
            end
            pc_reg  <= lc3_pkg::PC_RESET;
            psr_reg <= 16'h0000;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == lc3_pkg::CFG_SSP)
                begin
                    ssp_reg <= cfg_data;
                end
                else
                begin
                    vtb_reg <= cfg_data;
                end
            end
            if (ctrl.fetch && item_reg.mode == lc3_pkg::MODE_SETPC)
            begin
                pc_reg <= item_reg.address;
            end
            if (ctrl.decode)
            begin
                case (op)
                    lc3_pkg::OP_BR:
                        pc_reg <= ((dr & psr_reg[2:0]) != 3'b000) ? pc9_f : pc_inc;
                    lc3_pkg::OP_ADD, lc3_pkg::OP_AND, lc3_pkg::OP_NOT, lc3_pkg::OP_LEA:
                    begin
                        pc_reg <= pc_inc;
                        gpr_reg[dr] <= alu_v;
                        psr_reg <= lc3_pkg::codes(psr_reg, alu_v);
                    end
                    lc3_pkg::OP_JSR:
                    begin
                        pc_reg <= mdr_reg[11] ? pc_inc + lc3_pkg::sext(mdr_reg, 11)
                                              : gpr_reg[sr1];
                        gpr_reg[7] <= pc_inc;
                    end
                    lc3_pkg::OP_JMP: pc_reg <= gpr_reg[sr1];
                    lc3_pkg::OP_TRAP:
                    begin
                        pc_reg <= pc_inc;
                        gpr_reg[7] <= pc_inc;
                    end
                    lc3_pkg::OP_RES:
                    begin
                        pc_reg <= pc_inc;
                        psr_reg <= {1'b0, psr_reg[14:0]};
                        gpr_reg[6] <= ssp_reg - 16'd2;
                    end
                    lc3_pkg::OP_RTI:
                    begin
                        pc_reg <= pc_inc;
                        if (psr_reg[15])
                        begin
                            psr_reg <= {1'b0, psr_reg[14:0]};
                            gpr_reg[6] <= ssp_reg - 16'd2;
                        end
                    end
                    default: pc_reg <= pc_inc;
                endcase
            end
            if (ctrl.mem1)
            begin
                case (ir_reg[15:12])
                    lc3_pkg::OP_LD, lc3_pkg::OP_LDR:
                    begin
                        gpr_reg[ir_reg[11:9]] <= mdr_reg;
                        psr_reg <= lc3_pkg::codes(psr_reg, mdr_reg);
                    end
                    lc3_pkg::OP_TRAP: pc_reg <= mdr_reg;
                    lc3_pkg::OP_RTI:  pc_reg <= mdr_reg;
                    default: pc_reg <= pc_reg;
                endcase
            end
            if (ctrl.mem2)
            begin
                if (ir_reg[15:12] == lc3_pkg::OP_LDI)
                begin
                    gpr_reg[ir_reg[11:9]] <= mdr_reg;
                    psr_reg <= lc3_pkg::codes(psr_reg, mdr_reg);
                end
                else if (ir_reg[15:12] == lc3_pkg::OP_RTI)
                begin
                    psr_reg <= mdr_reg;
                    gpr_reg[6] <= gpr_reg[6] + 16'd2;
                end
            end
            if (ctrl.mcr && exc_reg != lc3_pkg::EXC_NONE)
            begin
                pc_reg <= mdr_reg;
            end
        end
    end

    // Per-item working registers; these hold payload only.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_item)
        begin
            item_reg <= in_word;
            ir_reg <= 16'h0000;
            wr_reg <= 1'b0;
            widx_reg <= 3'd0;
            wval_reg <= 16'h0000;
            exc_reg <= lc3_pkg::EXC_NONE;
            rdata_reg <= 16'h0000;
        end
        if (ctrl.fetch)
        begin
            ea_reg <= ssp_reg - 16'd1;
        end
        if (ctrl.decode)
        begin
            ir_reg <= mdr_reg;
            old_psr_reg <= psr_reg;
            st_data_reg <= gpr_reg[dr];
            ea_reg <= ea_d;
            case (op)
                lc3_pkg::OP_ADD, lc3_pkg::OP_AND, lc3_pkg::OP_NOT, lc3_pkg::OP_LEA:
                begin
                    wr_reg <= 1'b1;
                    widx_reg <= dr;
                    wval_reg <= alu_v;
                end
                lc3_pkg::OP_LD, lc3_pkg::OP_LDR, lc3_pkg::OP_LDI:
                begin
                    wr_reg <= 1'b1;
                    widx_reg <= dr;
                end
                lc3_pkg::OP_JSR, lc3_pkg::OP_TRAP:
                begin
                    wr_reg <= 1'b1;
                    widx_reg <= 3'd7;
                    wval_reg <= pc_inc;
                end
                lc3_pkg::OP_RES:
                begin
                    wr_reg <= 1'b1;
                    widx_reg <= 3'd6;
                    wval_reg <= ssp_reg - 16'd2;
                    exc_reg <= lc3_pkg::EXC_RESERVED;
                end
                lc3_pkg::OP_RTI:
                begin
                    wr_reg <= 1'b1;
                    widx_reg <= 3'd6;
                    wval_reg <= psr_reg[15] ? ssp_reg - 16'd2 : gpr_reg[6] + 16'd2;
                    exc_reg <= psr_reg[15] ? lc3_pkg::EXC_PRIV : lc3_pkg::EXC_NONE;
                end
                default: wr_reg <= 1'b0;
            endcase
        end
        if (ctrl.mem1)
        begin
            ea_reg <= ea_reg + 16'd1;
            if (ir_reg[15:12] == lc3_pkg::OP_LD || ir_reg[15:12] == lc3_pkg::OP_LDR)
            begin
                wval_reg <= mdr_reg;
            end
        end
        if (ctrl.mem2 && ir_reg[15:12] == lc3_pkg::OP_LDI)
        begin
            wval_reg <= mdr_reg;
        end
        if (ctrl.exc1)
        begin
            ea_reg <= ea_reg - 16'd1;
        end
        if (ctrl.exc2)
        begin
            ea_reg <= vtb_reg + ((exc_reg == lc3_pkg::EXC_PRIV) ? 16'd0 : 16'd1);
        end
        if (ctrl.fetch && item_reg.mode == lc3_pkg::MODE_READ)
        begin
            rdata_reg <= 16'h0000;
        end
        if (ctrl.mcr)
        begin
            if (item_reg.mode == lc3_pkg::MODE_READ)
            begin
                rdata_reg <= mdr_reg;
            end
        end
    end

    // The machine control word is the last read and stays in the read data
    // register while the result waits.
    assign stat.mode = item_reg.mode;
    assign stat.op = (ctrl.decode) ? op : ir_reg[15:12];
    assign stat.user_mode = psr_reg[15];

    assign out_word.pc_after = pc_reg;
    assign out_word.instruction_word = ir_reg;
    assign out_word.status_word = psr_reg;
    assign out_word.read_data = rdata_reg;
    assign out_word.register_written = wr_reg;
    assign out_word.register_index = widx_reg;
    assign out_word.register_value = wval_reg;
    assign out_word.exception_taken = exc_reg;
    assign out_word.machine_running = mdr_reg[15];

endmodule

// ===== hw/rtl/lc3_instruction_executor.sv =====
// ----------------------------------------------------------------------------
// lc3_instruction_executor
// Sixteen-bit processor core with a word memory, driven one item at a time.
// ----------------------------------------------------------------------------
//  channel | signals                      | word
//  input   | in_valid, in_ready, in_data  | mode, address, write data
//  output  | out_valid, out_ready, out_data | pc, ir, psr, register write
//  config  | cfg_we, cfg_index, cfg_data  | stack base, vector base
// An item passes fetch, then for instructions up to two dependent reads or
// writes, or two stack pushes and a vector read on an exception, and last
// a machine control read, one at a time on the single memory port.
// Reset clears core registers and state, not memory or per-item registers.
// A result waiting on out_ready holds the block.
// ----------------------------------------------------------------------------
module lc3_instruction_executor
#(
    parameter int ADDRESS_BITS = lc3_pkg::ADDRESS_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  lc3_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lc3_pkg::out_word_t out_data
);

    lc3_pkg::ctrl_t ctrl;
    lc3_pkg::stat_t stat;

    lc3_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    lc3_datapath #(.ADDRESS_BITS(ADDRESS_BITS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_data),
        .ctrl      (ctrl),
        .stat      (stat),
        .out_word  (out_data)
    );

endmodule

// ===== bench/tb_lc3_instruction_executor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lc3_instruction_executor
// Drives memory writes, pc loads, single instruction steps and memory reads
// into the processor core and checks every result word against a predictor
// that keeps its own copy of memory, registers, pc, status and configuration.
// Memory is always written before the core can read it.
// ----------------------------------------------------------------------------

// Predictor and scoreboard for the processor core.
class core_scoreboard;
    bit [15:0] mem [65536];
    bit        seen [65536];
    bit [15:0] regs [8];
    bit [15:0] pc;
    bit [15:0] psr;
    bit [15:0] stack_base;
    bit [15:0] vector_base;
    lc3_pkg::out_word_t expected_q [$];
    int errors;
    int accepted;
    int checked;
    int op_hits [16];
    int exceptions;

    function new();
        foreach (regs[i])
        begin
            regs[i] = '0;
        end
        pc = lc3_pkg::PC_RESET;
        psr = '0;
        stack_base = lc3_pkg::SSP_RESET;
        vector_base = lc3_pkg::VTB_RESET;
    endfunction

    function bit [15:0] sx(bit [15:0] v, int bits);
        bit [15:0] t;
        t = v << (16 - bits);
        return 16'($signed(t) >>> (16 - bits));
    endfunction

    function void store(bit [15:0] a, bit [15:0] v);
        mem[a] = v;
        seen[a] = 1'b1;
    endfunction

    function void set_codes(bit [15:0] v);
        psr = {psr[15:8], 5'b0, (v == 16'h0) ? 3'b010 : (v[15] ? 3'b100 : 3'b001)};
    endfunction

    // Exception entry: push status then pc on the supervisor stack.
    function bit [15:0] raise(bit [15:0] vec);
        bit [15:0] sp;
        bit [15:0] old;
        bit [15:0] va;
        old = psr;
        psr[15] = 1'b0;
        sp = stack_base - 16'd1;
        store(sp, old);
        sp = sp - 16'd1;
        store(sp, pc);
        regs[6] = sp;
        va = vector_base + vec;
        pc = mem[va];
        exceptions++;
        return sp;
    endfunction

    // Note an accepted input word and queue the result it must produce.
    function void note(lc3_pkg::in_word_t w);
        lc3_pkg::out_word_t e;
        bit [15:0] ir;
        bit [15:0] p9;
        bit [15:0] v;
        bit [15:0] b;
        bit [15:0] ea;
        bit [15:0] sp;
        bit [15:0] sp1;
        bit [3:0]  op;
        bit [2:0]  dr;
        bit [2:0]  s1;
        e = '0;
        accepted++;
        case (w.mode)
            lc3_pkg::MODE_WRITE: store(w.address, w.write_data);
            lc3_pkg::MODE_SETPC: pc = w.address;
            lc3_pkg::MODE_READ: e.read_data = mem[w.address];
            default:
            begin
                ir = mem[pc];
                pc = pc + 16'd1;
                op = ir[15:12];
                dr = ir[11:9];
                s1 = ir[8:6];
                p9 = pc + sx(ir, 9);
                e.instruction_word = ir;
                op_hits[op]++;
                case (op)
                    lc3_pkg::OP_BR:
                    begin
                        if ((ir[11:9] & psr[2:0]) != 3'b0)
                        begin
                            pc = p9;
                        end
                    end
                    lc3_pkg::OP_ADD, lc3_pkg::OP_AND:
                    begin
                        b = ir[5] ? sx(ir, 5) : regs[ir[2:0]];
                        v = (op == lc3_pkg::OP_ADD) ? regs[s1] + b : regs[s1] & b;
                        set_codes(v);
                        e.register_written = 1'b1; e.register_index = dr; e.register_value = v;
                    end
                    lc3_pkg::OP_LD, lc3_pkg::OP_LDI, lc3_pkg::OP_LEA:
                    begin
                        if (op == lc3_pkg::OP_LD)
                        begin
                            v = mem[p9];
                        end
                        else if (op == lc3_pkg::OP_LDI)
                        begin
                            ea = mem[p9];
                            v = mem[ea];
                        end
                        else
                        begin
                            v = p9;
                        end
                        set_codes(v);
                        e.register_written = 1'b1; e.register_index = dr; e.register_value = v;
                    end
                    lc3_pkg::OP_ST: store(p9, regs[dr]);
                    lc3_pkg::OP_STI: store(mem[p9], regs[dr]);
                    lc3_pkg::OP_JSR:
                    begin
                        e.register_written = 1'b1; e.register_index = 3'd7;
                        e.register_value = pc;
                        pc = ir[11] ? pc + sx(ir, 11) : regs[s1];
                    end
                    lc3_pkg::OP_LDR, lc3_pkg::OP_STR:
                    begin
                        ea = regs[s1] + sx(ir, 6);
                        if (op == lc3_pkg::OP_LDR)
                        begin
                            v = mem[ea];
                            set_codes(v);
                            e.register_written = 1'b1; e.register_index = dr;
                            e.register_value = v;
                        end
                        else
                        begin
                            store(ea, regs[dr]);
                        end
                    end
                    lc3_pkg::OP_RTI:
                    begin
                        e.register_written = 1'b1; e.register_index = 3'd6;
                        if (psr[15])
                        begin
                            e.register_value = raise(16'd0);
                            e.exception_taken = lc3_pkg::EXC_PRIV;
                        end
                        else
                        begin
                            sp = regs[6];
                            sp1 = sp + 16'd1;
                            pc = mem[sp];
                            psr = mem[sp1];
                            e.register_value = sp + 16'd2;
                        end
                    end
                    lc3_pkg::OP_NOT:
                    begin
                        v = ~regs[s1];
                        set_codes(v);
                        e.register_written = 1'b1; e.register_index = dr; e.register_value = v;
                    end
                    lc3_pkg::OP_JMP: pc = regs[s1];
                    lc3_pkg::OP_RES:
                    begin
                        e.register_written = 1'b1; e.register_index = 3'd6;
                        e.register_value = raise(16'd1);
                        e.exception_taken = lc3_pkg::EXC_RESERVED;
                    end
                    default:
                    begin
                        e.register_written = 1'b1; e.register_index = 3'd7;
                        e.register_value = pc;
                        pc = mem[{8'h00, ir[7:0]}];
                    end
                endcase
                if (e.register_written)
                begin
                    regs[e.register_index] = e.register_value;
                end
            end
        endcase
        e.pc_after = pc;
        e.status_word = psr;
        e.machine_running = mem[lc3_pkg::MCR_ADDRESS][15];
        expected_q.push_back(e);
    endfunction

    function void field(string name, bit [15:0] exp_v, bit [15:0] got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, exp_v, got_v);
            errors++;
        end
    endfunction

    // Check one result word against the oldest expectation.
    function void check(lc3_pkg::out_word_t got);
        lc3_pkg::out_word_t e;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        checked++;
        field("pc_after", e.pc_after, got.pc_after);
        field("instruction_word", e.instruction_word, got.instruction_word);
        field("status_word", e.status_word, got.status_word);
        field("read_data", e.read_data, got.read_data);
        field("register_written", 16'(e.register_written), 16'(got.register_written));
        field("register_index", 16'(e.register_index), 16'(got.register_index));
        field("register_value", e.register_value, got.register_value);
        field("exception_taken", 16'(e.exception_taken), 16'(got.exception_taken));
        field("machine_running", 16'(e.machine_running), 16'(got.machine_running));
    endfunction
endclass

module tb_lc3_instruction_executor;

    localparam int ITEM_COUNT  = 1750;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD   = 400;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic      cfg_index;
    logic [15:0] cfg_data;
    logic      in_valid;
    logic      in_ready;
    lc3_pkg::in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    lc3_pkg::out_word_t out_data;

    core_scoreboard sb;
    int  next_gap;
    bit  quiet;
    bit  hold_request;
    int  cycles;

    lc3_instruction_executor DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Watchdog.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Send one word; valid stays up between back-to-back words. Ready is
    // sampled mid-cycle so the accepting edge is known before it happens.
    task automatic send(lc3_pkg::in_word_t w);
        if (next_gap > 0)
        begin
            repeat (next_gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(negedge clk);
        while (!in_ready)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        sb.note(w);
        if ($urandom_range(0, 63) == 0)
        begin
            quiet = ~quiet;
        end
        next_gap = quiet ? 0 : $urandom_range(0, 13);
        if (next_gap > 0)
        begin
            in_valid <= 1'b0;
        end
    endtask

    task automatic send_fields(logic [1:0] mode, logic [15:0] a, logic [15:0] d);
        lc3_pkg::in_word_t w;
        w.mode = mode;
        w.address = a;
        w.write_data = d;
        send(w);
    endtask

    // Make sure a word the core will read holds known data, sometimes fresh.
    task automatic prepare(bit [15:0] a, bit [15:0] keep);
        if (a != sb.pc && a != keep && (!sb.seen[a] || $urandom_range(0, 1) == 1))
        begin
            send_fields(lc3_pkg::MODE_WRITE, a, 16'($urandom));
        end
    endtask

    // Place one instruction at pc, set up its operands and execute it.
    task automatic run_instr(bit [3:0] op);
        bit [15:0] ir;
        bit [15:0] p9;
        bit [15:0] sp;
        ir = {op, 12'($urandom)};
        send_fields(lc3_pkg::MODE_WRITE, sb.pc, ir);
        p9 = sb.pc + 16'd1 + sb.sx(ir, 9);
        case (op)
            lc3_pkg::OP_LD, lc3_pkg::OP_STI: prepare(p9, sb.pc);
            lc3_pkg::OP_LDI:
            begin
                prepare(p9, sb.pc);
                prepare(sb.mem[p9], p9);
            end
            lc3_pkg::OP_LDR: prepare(sb.regs[ir[8:6]] + sb.sx(ir, 6), sb.pc);
            lc3_pkg::OP_RTI:
            begin
                if (sb.psr[15])
                begin
                    prepare(sb.vector_base, sb.pc);
                end
                else
                begin
                    sp = sb.regs[6];
                    prepare(sp, sb.pc);
                    prepare(sp + 16'd1, sp);
                end
            end
            lc3_pkg::OP_RES: prepare(sb.vector_base + 16'd1, sb.pc);
            lc3_pkg::OP_TRAP: prepare({8'h00, ir[7:0]}, sb.pc);
            default: ;
        endcase
        send_fields(lc3_pkg::MODE_EXEC, 16'($urandom), 16'($urandom));
    endtask

    // Wait until the core is idle, then write one configuration register.
    task automatic write_config(logic idx, logic [15:0] value);
        if (next_gap == 0)
        begin
            in_valid <= 1'b0;
            next_gap = 1;
        end
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == lc3_pkg::CFG_SSP)
        begin
            sb.stack_base = value;
        end
        else
        begin
            sb.vector_base = value;
        end
    endtask

    function automatic bit [15:0] pick_address();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off on request. Valid is
    // sampled mid-cycle and the word is checked after the accepting edge.
    initial
    begin
        int gap;
        lc3_pkg::out_word_t got;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = quiet ? 0 : $urandom_range(0, 13);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(negedge clk);
            while (!out_valid)
            begin
                @(negedge clk);
            end
            got = out_data;
            @(posedge clk);
            sb.check(got);
        end
    end

    // Main sequence.
    initial
    begin
        bit [15:0] ssp_set [4];
        bit [15:0] vtb_set [4];
        int r;
        int drain;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        next_gap = 0;
        quiet = 1'b0;
        hold_request = 1'b0;
        ssp_set = '{16'hFFFF, 16'h0000, 16'($urandom), lc3_pkg::SSP_RESET};
        vtb_set = '{16'h0000, 16'hFFFF, 16'($urandom), lc3_pkg::VTB_RESET};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: machine control word first, extremes, every opcode.
        send_fields(lc3_pkg::MODE_WRITE, lc3_pkg::MCR_ADDRESS, 16'h8000);
        send_fields(lc3_pkg::MODE_WRITE, 16'h0000, 16'hFFFF);
        send_fields(lc3_pkg::MODE_WRITE, 16'hFFFF, 16'h0000);
        send_fields(lc3_pkg::MODE_READ, 16'h0000, 16'hFFFF);
        send_fields(lc3_pkg::MODE_READ, 16'hFFFF, 16'h0000);
        send_fields(lc3_pkg::MODE_SETPC, 16'hFFFF, 16'h0000);
        run_instr(lc3_pkg::OP_ADD);
        send_fields(lc3_pkg::MODE_SETPC, 16'h4000, 16'h0000);
        for (int op = 0; op < 16; op++)
        begin
            run_instr(op[3:0]);
        end

        // Random phases, each under its own configuration.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_config(lc3_pkg::CFG_SSP, ssp_set[ph]);
            write_config(lc3_pkg::CFG_VTB, vtb_set[ph]);
            if (ph == 1)
            begin
                hold_request = 1'b1;
            end
            while (sb.accepted < (ph + 1) * ITEM_COUNT / 4)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    send_fields(lc3_pkg::MODE_WRITE, pick_address(), 16'($urandom));
                end
                else if (r < 14)
                begin
                    send_fields(lc3_pkg::MODE_WRITE, sb.pc, 16'($urandom));
                    send_fields(lc3_pkg::MODE_READ, sb.pc, 16'($urandom));
                end
                else if (r < 18)
                begin
                    send_fields(lc3_pkg::MODE_SETPC, pick_address(), 16'($urandom));
                end
                else
                begin
                    run_instr(4'($urandom_range(0, 15)));
                end
            end
        end

        if (next_gap == 0)
        begin
            in_valid <= 1'b0;
        end
        drain = 0;
        while (sb.expected_q.size() != 0 && drain < 20000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (sb.expected_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
            sb.errors++;
        end
        $display("Covered %0d words, %0d results checked, %0d exceptions taken.",
                 sb.accepted, sb.checked, sb.exceptions);
        $display("Instructions by opcode: %p", sb.op_hits);
        if (sb.errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lc3_pkg.sv
hw/rtl/lc3_ctrl.sv
hw/rtl/lc3_datapath.sv
hw/rtl/lc3_instruction_executor.sv
bench/tb_lc3_instruction_executor.sv
